### src/story_id_string_parser_macros.svh
// Assertion helpers shared by the parser modules.
`ifndef STORY_ID_STRING_PARSER_MACROS_SVH
`define STORY_ID_STRING_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SIDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SIDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/sidp_pkg.sv
`timescale 1ns / 1ps

package sidp_pkg;

    localparam logic [2:0] KIND_UUID    = 3'd0;
    localparam logic [2:0] KIND_ZCODE   = 3'd1;
    localparam logic [2:0] KIND_GLULX_R = 3'd2;
    localparam logic [2:0] KIND_GLULX_M = 3'd3;
    localparam logic [2:0] KIND_MD5     = 3'd4;

    localparam logic [30:0] REL_MAX      = 31'h7fffffff;
    localparam logic [31:0] ZCODE_CK_MAX = 32'h0000ffff;
    localparam logic [31:0] CK_NONE      = 32'hffffffff;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic        id_valid;
        logic [2:0]  id_kind;
        logic [63:0] digest_high;
        logic [63:0] digest_low;
        logic [30:0] release_number;
        logic [47:0] serial_bytes;
        logic [31:0] checksum_value;
        logic [31:0] memory_size;
    } t_out_item;

endpackage

### src/sidp_parse_core.sv
`timescale 1ns / 1ps
`include "story_id_string_parser_macros.svh"

module sidp_parse_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  sidp_pkg::t_in_item i_item,
    output logic               o_push,
    output sidp_pkg::t_out_item o_result
);
    import sidp_pkg::*;

    typedef enum logic [4:0] {
        PH_LEAD, PH_UPFX, PH_ZPFX, PH_GPFX, PH_TPFX, PH_UBODY, PH_UTAIL,
        PH_ZREL, PH_ZSER, PH_ZAFTER, PH_ZCK, PH_ZTRAIL, PH_GSEG, PH_GMCK,
        PH_GMTRAIL, PH_GSER, PH_GDASH, PH_GRCK, PH_GRTRAIL, PH_MD5, PH_MTRAIL
    } t_phase;

    localparam logic [55:0] PFX_UUID  = "uuid://";
    localparam logic [55:0] PFX_ZCODE = {"zcode-", 8'h00};
    localparam logic [55:0] PFX_GLULX = {"glulx-", 8'h00};
    localparam logic [55:0] PFX_TADS  = {"tads-", 16'h0000};

    function automatic logic [7:0] pfx_pick(input logic [55:0] s, input logic [2:0] pos);
        logic [55:0] sh;
        sh = s << {pos, 3'b000};
        return sh[55:48];
    endfunction

    // Control state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [5:0]  r_nib, n_nib;
    logic        r_digit_only, n_digit_only;
    logic        r_hex_only, n_hex_only;
    logic        r_err, n_err;

    // Accumulators and holds
    logic [127:0] r_digest, n_digest;
    logic [30:0]  r_dec, n_dec;
    logic [31:0]  r_hex, n_hex;
    logic [30:0]  r_rel, n_rel;
    logic [47:0]  r_serial, n_serial;
    logic [31:0]  r_memsize, n_memsize;

    // Character classes
    logic [7:0]  c, lc;
    logic        is_ws, is_dig, is_hex;
    logic [3:0]  hv;

    logic [34:0] dec_wide;
    logic [30:0] dec_next;
    logic [5:0]  nib_inc;
    logic [2:0]  pos_inc;

    logic        do_start;
    t_phase      start_phase;
    logic [55:0] pfx_str;
    logic [2:0]  pfx_len;
    t_phase      pfx_next;

    t_out_item   res;

    always_comb begin
        c      = i_item.char_in;
        lc     = (c inside {[8'h41:8'h5a]}) ? (c | 8'h20) : c;
        is_ws  = c inside {8'h20, 8'h09, 8'h0a, 8'h0d};
        is_dig = c inside {[8'h30:8'h39]};
        is_hex = 1'b0;
        hv     = 4'd0;
        if (is_dig) begin
            is_hex = 1'b1;
            hv     = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            is_hex = 1'b1;
            hv     = c[3:0] + 4'd9;
        end
        // Release saturates rather than wrapping: x*10 + d, clamped.
        dec_wide = {1'b0, r_dec, 3'b000} + {3'b000, r_dec, 1'b0} + {31'd0, hv};
        dec_next = (dec_wide > {4'd0, REL_MAX}) ? REL_MAX : dec_wide[30:0];
        nib_inc  = (r_nib == 6'd63) ? r_nib : r_nib + 6'd1;
        pos_inc  = r_pos + 3'd1;
    end

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_nib        = r_nib;
        n_digit_only = r_digit_only;
        n_hex_only   = r_hex_only;
        n_err        = r_err;
        n_digest     = r_digest;
        n_dec        = r_dec;
        n_hex        = r_hex;
        n_rel        = r_rel;
        n_serial     = r_serial;
        n_memsize    = r_memsize;
        do_start     = 1'b0;
        start_phase  = PH_LEAD;
        pfx_str      = PFX_UUID;
        pfx_len      = 3'd7;
        pfx_next     = PH_UBODY;

        case (r_phase)
            PH_ZPFX: begin
                pfx_str  = PFX_ZCODE;
                pfx_len  = 3'd6;
                pfx_next = PH_ZREL;
            end
            PH_GPFX: begin
                pfx_str  = PFX_GLULX;
                pfx_len  = 3'd6;
                pfx_next = PH_GSEG;
            end
            PH_TPFX: begin
                pfx_str  = PFX_TADS;
                pfx_len  = 3'd5;
                pfx_next = PH_MD5;
            end
            default: begin
            end
        endcase

        if (!r_err) begin
            if (c == 8'h00) begin
                n_err = 1'b1;
            end else begin
                case (r_phase)
                    PH_LEAD: begin
                        if (!is_ws) begin
                            n_pos = 3'd1;
                            if (lc == "u") begin
                                n_phase = PH_UPFX;
                            end else if (lc == "z") begin
                                n_phase = PH_ZPFX;
                            end else if (lc == "g") begin
                                n_phase = PH_GPFX;
                            end else if (lc == "t") begin
                                n_phase = PH_TPFX;
                            end else if (is_hex) begin
                                // A bare hex digit opens an md5 body directly.
                                n_phase      = PH_MD5;
                                n_pos        = 3'd0;
                                n_nib        = 6'd1;
                                n_hex        = '0;
                                n_dec        = '0;
                                n_digit_only = 1'b1;
                                n_hex_only   = 1'b1;
                                n_digest     = {r_digest[123:0], hv};
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                    end
                    PH_UPFX, PH_ZPFX, PH_GPFX, PH_TPFX: begin
                        if (r_pos >= pfx_len || lc != pfx_pick(pfx_str, r_pos)) begin
                            n_err = 1'b1;
                        end else begin
                            n_pos = pos_inc;
                            if (pos_inc == pfx_len) begin
                                do_start    = 1'b1;
                                start_phase = pfx_next;
                            end
                        end
                    end
                    PH_UBODY: begin
                        if (c != "-") begin
                            if (!is_hex) begin
                                n_err = 1'b1;
                            end else begin
                                n_digest = {r_digest[123:0], hv};
                                n_nib    = nib_inc;
                                if (nib_inc >= 6'd32) begin
                                    n_phase = PH_UTAIL;
                                end
                            end
                        end
                    end
                    PH_UTAIL: begin
                        if (!is_ws && c != "/") begin
                            n_err = 1'b1;
                        end
                    end
                    PH_ZREL: begin
                        if (is_dig) begin
                            n_dec = dec_next;
                            n_nib = nib_inc;
                        end else if (c == "-" && r_nib != 6'd0) begin
                            n_rel   = r_dec;
                            n_pos   = 3'd0;
                            n_phase = PH_ZSER;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_ZSER, PH_GSER: begin
                        n_serial = {r_serial[39:0], c};
                        n_pos    = pos_inc;
                        if (pos_inc >= 3'd6) begin
                            n_phase = (r_phase == PH_ZSER) ? PH_ZAFTER : PH_GDASH;
                        end
                    end
                    PH_ZAFTER: begin
                        if (c == "-") begin
                            do_start    = 1'b1;
                            start_phase = PH_ZCK;
                        end else if (is_ws) begin
                            n_hex   = CK_NONE;
                            n_phase = PH_ZTRAIL;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_ZCK, PH_GMCK, PH_GRCK: begin
                        if (is_hex) begin
                            n_hex = {r_hex[27:0], hv};
                            n_nib = nib_inc;
                        end else if (is_ws && r_nib != 6'd0) begin
                            case (r_phase)
                                PH_ZCK: begin
                                    n_phase = PH_ZTRAIL;
                                    if (r_hex > ZCODE_CK_MAX) begin
                                        n_err = 1'b1;
                                    end
                                end
                                PH_GMCK: n_phase = PH_GMTRAIL;
                                default: n_phase = PH_GRTRAIL;
                            endcase
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_GSEG: begin
                        if (c == "-") begin
                            if (r_nib >= 6'd8) begin
                                if (!r_hex_only) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_memsize   = r_hex;
                                    do_start    = 1'b1;
                                    start_phase = PH_GMCK;
                                end
                            end else if (r_nib == 6'd0 || !r_digit_only) begin
                                n_err = 1'b1;
                            end else begin
                                n_rel   = r_dec;
                                n_pos   = 3'd0;
                                n_phase = PH_GSER;
                            end
                        end else begin
                            if (is_dig) begin
                                n_dec = dec_next;
                            end else begin
                                n_digit_only = 1'b0;
                            end
                            if (is_hex) begin
                                n_hex = {r_hex[27:0], hv};
                            end else begin
                                n_hex_only = 1'b0;
                            end
                            n_nib = nib_inc;
                        end
                    end
                    PH_GDASH: begin
                        if (c == "-") begin
                            do_start    = 1'b1;
                            start_phase = PH_GRCK;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_MD5: begin
                        if (is_hex && r_nib < 6'd32) begin
                            n_digest = {r_digest[123:0], hv};
                            n_nib    = nib_inc;
                        end else if (is_ws && r_nib == 6'd32) begin
                            n_phase = PH_MTRAIL;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    PH_ZTRAIL, PH_GMTRAIL, PH_GRTRAIL, PH_MTRAIL: begin
                        if (!is_ws) begin
                            n_err = 1'b1;
                        end
                    end
                    default: begin
                        n_err = 1'b1;
                    end
                endcase
            end
        end

        if (do_start) begin
            n_phase      = start_phase;
            n_nib        = 6'd0;
            n_hex        = '0;
            n_dec        = '0;
            n_pos        = 3'd0;
            n_digit_only = 1'b1;
            n_hex_only   = 1'b1;
        end
    end

    // Result as seen after the current character has been taken in.
    always_comb begin
        logic       ok;
        logic [2:0] kind;
        logic [31:0] ck;
        ok   = 1'b0;
        kind = KIND_UUID;
        ck   = n_hex;
        res  = '0;
        if (!n_err) begin
            case (n_phase)
                PH_UTAIL: begin
                    ok   = 1'b1;
                    kind = KIND_UUID;
                end
                PH_ZAFTER: begin
                    ok   = 1'b1;
                    kind = KIND_ZCODE;
                    ck   = CK_NONE;
                end
                PH_ZCK: begin
                    ok   = (n_nib != 6'd0) && (n_hex <= ZCODE_CK_MAX);
                    kind = KIND_ZCODE;
                end
                PH_ZTRAIL: begin
                    ok   = 1'b1;
                    kind = KIND_ZCODE;
                end
                PH_GRCK: begin
                    ok   = n_nib != 6'd0;
                    kind = KIND_GLULX_R;
                end
                PH_GRTRAIL: begin
                    ok   = 1'b1;
                    kind = KIND_GLULX_R;
                end
                PH_GMCK: begin
                    ok   = n_nib != 6'd0;
                    kind = KIND_GLULX_M;
                end
                PH_GMTRAIL: begin
                    ok   = 1'b1;
                    kind = KIND_GLULX_M;
                end
                PH_MD5: begin
                    ok   = n_nib == 6'd32;
                    kind = KIND_MD5;
                end
                PH_MTRAIL: begin
                    ok   = 1'b1;
                    kind = KIND_MD5;
                end
                default: begin
                end
            endcase
        end
        if (ok) begin
            res.id_valid = 1'b1;
            res.id_kind  = kind;
            if (kind == KIND_UUID || kind == KIND_MD5) begin
                res.digest_high = n_digest[127:64];
                res.digest_low  = n_digest[63:0];
            end else if (kind == KIND_ZCODE || kind == KIND_GLULX_R) begin
                res.release_number = n_rel;
                res.serial_bytes   = n_serial;
                res.checksum_value = ck;
            end else begin
                res.checksum_value = ck;
                res.memory_size    = n_memsize;
            end
        end
    end

    // The last character of a string returns the parser to its starting state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_item.last_char)) begin
            r_phase      <= PH_LEAD;
            r_pos        <= 3'd0;
            r_nib        <= 6'd0;
            r_digit_only <= 1'b1;
            r_hex_only   <= 1'b1;
            r_err        <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_nib        <= n_nib;
            r_digit_only <= n_digit_only;
            r_hex_only   <= n_hex_only;
            r_err        <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_digest  <= n_digest;
            r_dec     <= n_dec;
            r_hex     <= n_hex;
            r_rel     <= n_rel;
            r_serial  <= n_serial;
            r_memsize <= n_memsize;
        end
    end

    assign o_push   = i_accept && i_item.last_char;
    assign o_result = res;

    `SIDP_ASSERT_NEXT(a_restart_after_last, i_clk, i_rst_n, i_accept && i_item.last_char, r_phase == PH_LEAD && !r_err && r_nib == 6'd0)
    `SIDP_ASSERT_NOW(a_invalid_is_zero, i_clk, i_rst_n, o_push && !o_result.id_valid, o_result.id_kind == KIND_UUID && o_result.memory_size == 32'd0)
    `SIDP_ASSERT_NOW(a_digest_full, i_clk, i_rst_n, r_phase == PH_UTAIL || r_phase == PH_MTRAIL, r_nib == 6'd32)

endmodule

### src/sidp_out_queue.sv
`timescale 1ns / 1ps
`include "story_id_string_parser_macros.svh"

module sidp_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sidp_pkg::t_out_item i_item,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output sidp_pkg::t_out_item o_item
);
    import sidp_pkg::*;

    logic      r_head_valid, r_skid_valid;
    t_out_item r_head, r_skid;
    logic      pop;

    assign pop = r_head_valid && !i_stall;

    // A push never coincides with a full skid entry: the input is stalled then.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_head_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_head_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_head_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
            end else if (i_push) begin
                r_head <= i_item;
            end
        end else if (i_push) begin
            if (r_head_valid) begin
                r_skid <= i_item;
            end else begin
                r_head <= i_item;
            end
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_item  = r_head;

    `SIDP_ASSERT_NOW(a_skid_behind_head, i_clk, i_rst_n, r_skid_valid, r_head_valid)
    `SIDP_ASSERT_NEXT(a_push_into_skid, i_clk, i_rst_n, r_head_valid && i_stall && i_push, r_skid_valid && r_head_valid)
    `SIDP_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, r_skid_valid, !i_push)

endmodule

### src/story_id_string_parser.sv
`timescale 1ns / 1ps
// Story identifier string parser: one character item per cycle while o_in_stall is low.
// The result for the last character is registered into the queue head, or into the skid entry while the head waits.
// Throughput: one character per cycle while o_in_stall is low, set by the combinational phase and accumulator update.
// A two-entry output queue lets characters flow while one result waits to be taken.
// Reset: synchronous, active low; clears the parse phase, counters, flags and the queue.
module story_id_string_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sidp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sidp_pkg::t_out_item o_out_item
);
    import sidp_pkg::*;

    logic      accept;
    logic      push;
    logic      full;
    t_out_item result;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    sidp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_result (result)
    );

    sidp_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule
